FILE: rtl/core/b64e_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the alphabet lookup for the base64 stream encoder
// depends on nothing; imported by every other file of the block but b64e_if
package b64e_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned SymW       = 6;
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned CntW       = $clog2(MaxChars);
  localparam int unsigned QDepthDflt = 2;

  localparam logic [CharW-1:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CntW-1:0]                last_idx;
    logic                           fin;
  } b64e_entry_t;

  function automatic logic [CharW-1:0] sym_char(logic [SymW-1:0] v);
    logic [CharW-1:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'h41;
    end else if (v < 6'd52) begin
      return w + 8'h47;
    end else if (v < 6'd62) begin
      return w - 8'h04;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

FILE: rtl/core/b64e_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the byte input and the character output
// standalone; used by the front, the back and the top level
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output code_char, output run_end, output message_end,
                  input ready);
  modport sink   (input valid, input code_char, input run_end, input message_end,
                  output ready);
endinterface

FILE: rtl/core/b64e_front.sv
`timescale 1ns / 1ps
// front end: takes message bytes, tracks group phase and leftover bits,
// builds the character bundle per byte; uses b64e_pkg and b64e_in_if
module b64e_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  b64e_in_if.sink               in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output b64e_pkg::b64e_entry_t push_entry_o
);
  import b64e_pkg::*;

  typedef enum logic [1:0] {PhStart, PhSecond, PhThird} phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  carry_q, carry_d;
  logic [7:0]  b;
  logic        fin;
  logic        accept;
  b64e_entry_t entry;

  assign b            = in_i.data_byte;
  assign fin          = in_i.is_final;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;
  assign push_entry_o = entry;

  always_comb begin
    entry       = '0;
    entry.chars = {MaxChars{PadChar}};
    entry.fin   = fin;
    phase_d     = phase_q;
    carry_d     = carry_q;
    unique case (phase_q)
      PhSecond: begin
        entry.chars[0] = sym_char({carry_q[1:0], b[7:4]});
        if (fin) begin
          entry.chars[1] = sym_char({b[3:0], 2'b00});
          entry.last_idx = CntW'(2);
        end else begin
          entry.last_idx = CntW'(0);
        end
        carry_d = b[3:0];
        phase_d = PhThird;
      end
      PhThird: begin
        entry.chars[0] = sym_char({carry_q, b[7:6]});
        entry.chars[1] = sym_char(b[5:0]);
        entry.last_idx = CntW'(1);
        carry_d        = '0;
        phase_d        = PhStart;
      end
      default: begin
        entry.chars[0] = sym_char(b[7:2]);
        if (fin) begin
          entry.chars[1] = sym_char({b[1:0], 4'b0000});
          entry.last_idx = CntW'(3);
        end else begin
          entry.last_idx = CntW'(0);
        end
        carry_d = {2'b00, b[1:0]};
        phase_d = PhSecond;
      end
    endcase
    if (fin) begin
      phase_d = PhStart;
      carry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      carry_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |=> (phase_q == PhStart && carry_q == 4'd0))
    else $error("group state not cleared after final byte");

  a_carry_fits_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSecond) |-> (carry_q[3:2] == 2'b00))
    else $error("carry holds more than two bits in second position");

endmodule

FILE: rtl/core/b64e_queue.sv
`timescale 1ns / 1ps
// short queue of character bundles between front and back
// uses b64e_pkg for the entry type
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QDepthDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  b64e_pkg::b64e_entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output b64e_pkg::b64e_entry_t pop_entry_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64e_entry_t      mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntQW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntQW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/b64e_back.sv
`timescale 1ns / 1ps
// back end: walks each bundle one character per cycle into the output register
// while out_o is ready; uses b64e_pkg and b64e_out_if
module b64e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  input  b64e_pkg::b64e_entry_t entry_i,
  output logic                  pop_o,
  b64e_out_if.source            out_o
);
  import b64e_pkg::*;

  logic [CntW-1:0]  idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             run_end_q, msg_end_q;
  logic             load, last;

  assign load  = entry_valid_i && (!valid_q || out_o.ready);
  assign last  = (idx_q == entry_i.last_idx);
  assign pop_o = load && last;

  assign out_o.valid       = valid_q;
  assign out_o.code_char   = char_q;
  assign out_o.run_end     = run_end_q;
  assign out_o.message_end = msg_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? '0 : idx_q + 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q    <= entry_i.chars[idx_q];
      run_end_q <= last;
      msg_end_q <= last && entry_i.fin;
    end
  end

  a_msg_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.message_end) |-> out_o.run_end)
    else $error("message end without run end");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_i |-> (idx_q <= entry_i.last_idx))
    else $error("character index past end of bundle");

endmodule

FILE: rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
// top level of the base64 stream encoder: front, queue and back joined
// uses b64e_pkg, b64e_if, b64e_front, b64e_queue and b64e_back
//
// Bytes go in on in_i with is_final on the last byte of a message; standard
// Base64 characters come out on out_o, one per cycle while out_o is ready,
// with run_end on the last character a byte causes and message_end on the
// last of the message, which is padded with '=' as needed. A byte is taken
// in the cycle it is offered while the bundle queue has room, so the input
// side runs at one byte per cycle in bursts; sustained, the single-character
// output register sets the pace: a byte at the first or second group
// position yields one character, one at the third yields two, and a final
// byte that leaves a partial group yields three or four. The first character
// of a byte passes through the bundle queue and then the output register
// before it is presented on out_o. There are no configuration registers.
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QDepthDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64e_in_if.sink    in_i,
  b64e_out_if.source out_o
);
  import b64e_pkg::*;

  logic        push_valid, push_ready;
  logic        pop_valid, pop;
  b64e_entry_t push_entry, pop_entry;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (pop_valid),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for base64_stream_encoder: directed and random messages
// depends on b64e_pkg, b64e_if and the encoder rtl; a scoreboard class predicts each character
module testbench;
  import b64e_pkg::*;

  typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD} grp_pos_e;

  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       message_end;
  } b64_char_t;

  class b64_char_board;
    string      alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64_char_t  expected_q[$];
    grp_pos_e   group_pos;
    logic [3:0] carry;
    int         errors;
    int         checked;

    function new();
      group_pos = GRP_FIRST;
      carry     = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function logic [7:0] sym(logic [5:0] v);
      return alphabet[v];
    endfunction

    // works out every character a taken byte releases
    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0] chars[$];
      b64_char_t  c;
      case (group_pos)
        GRP_SECOND: begin
          chars.push_back(sym({carry[1:0], b[7:4]}));
          carry     = b[3:0];
          group_pos = GRP_THIRD;
          if (fin) begin
            chars.push_back(sym({carry, 2'b00}));
            chars.push_back(PadChar);
          end
        end
        GRP_THIRD: begin
          chars.push_back(sym({carry, b[7:6]}));
          chars.push_back(sym(b[5:0]));
          carry     = '0;
          group_pos = GRP_FIRST;
        end
        default: begin
          chars.push_back(sym(b[7:2]));
          carry     = {2'b00, b[1:0]};
          group_pos = GRP_SECOND;
          if (fin) begin
            chars.push_back(sym({carry[1:0], 4'b0000}));
            chars.push_back(PadChar);
            chars.push_back(PadChar);
          end
        end
      endcase
      foreach (chars[i]) begin
        c.code_char   = chars[i];
        c.run_end     = (i == chars.size() - 1);
        c.message_end = fin && (i == chars.size() - 1);
        expected_q.push_back(c);
      end
      if (fin) begin
        group_pos = GRP_FIRST;
        carry     = '0;
      end
    endfunction

    function void check_char(logic [7:0] ch, logic re, logic me);
      b64_char_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected character %h (run_end %b message_end %b)", $time, ch, re, me);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (ch !== e.code_char) begin
        errors++;
        $display("%0t: code_char expected %h actual %h", $time, e.code_char, ch);
      end
      if (re !== e.run_end) begin
        errors++;
        $display("%0t: run_end expected %b actual %b", $time, e.run_end, re);
      end
      if (me !== e.message_end) begin
        errors++;
        $display("%0t: message_end expected %b actual %b", $time, e.message_end, me);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  b64_char_board board = new();

  int send_idle  = 0;
  int recv_stall = 0;
  int hold_req   = 0;
  int hold_left  = 0;
  int bytes_sent = 0;
  int msgs_sent  = 0;

  // {is_final, data_byte}: short messages at the field extremes and every group position
  logic [8:0] directed_words [0:20] = '{
    9'h100, 9'h1FF,
    9'h000, 9'h1FF,  9'h0FF, 9'h100,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h000, 9'h000, 9'h000, 9'h100,
    9'h0AA, 9'h055, 9'h0F0, 9'h00F, 9'h180
  };

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        board.note_byte(in_ch.data_byte, in_ch.is_final);
      end
      if (out_ch.valid && out_ch.ready) begin
        board.check_char(out_ch.code_char, out_ch.run_end, out_ch.message_end);
      end
    end
  end

  // receiver: random stalls plus a long hold-off when one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_final  <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (fin) msgs_sent++;
  endtask

  task automatic send_messages(input int n_bytes);
    int         len;
    int         stop_at;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(255));
        endcase
        send_byte(b, i == len - 1);
      end
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.is_final  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) send_byte(directed_words[i][7:0], directed_words[i][8]);

    send_messages(70);
    send_idle = 60;
    send_messages(70);
    send_idle  = 0;
    recv_stall = 60;
    send_messages(70);
    send_idle  = 15;
    recv_stall = 15;
    send_messages(70);

    // long hold-off on the output while bytes keep coming
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 150;
    send_messages(30);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: characters expected %0d more actual 0", $time, board.pending());
    end

    $display("%0d bytes in %0d messages sent, %0d characters checked",
             bytes_sent, msgs_sent, board.checked);
    $display("phases: no idling, sender idle, receiver stalls, both, long output hold-off");
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: base64_stream_encoder.f
rtl/core/b64e_pkg.sv
rtl/core/b64e_if.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
tb/testbench.sv
